// ===== rtl/core/tcw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console writer.
// No dependencies; text_console_writer and tcw_cursor import this package.
package tcw_pkg;

    // Default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Operation codes
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Control characters
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Configuration register indexes
    localparam int         CFG_IDX_W     = 4;
    localparam logic [3:0] CFG_FG_COLOUR = 4'd0;
    localparam logic [3:0] CFG_BG_COLOUR = 4'd1;

    localparam logic [3:0] FG_RESET = 4'd7;
    localparam logic [3:0] BG_RESET = 4'd0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  char_code;
        logic [7:0]  new_col;
        logic [7:0]  new_row;
        logic [10:0] cell_index;
    } tcw_in_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        scrolled;
    } tcw_out_t;

    // Decision made for one request by the cursor unit
    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic       scroll;
        logic [7:0] wr_char;
    } tcw_cmd_t;

endpackage

// ===== rtl/core/text_console_writer.sv =====
`timescale 1ns / 1ps
// Top level of the text console writer: request sequencer, colour registers,
// scroll and clear sweeps. Depends on tcw_pkg, tcw_cursor and tcw_screen_ram.
//
//  Channel   Ports                            Direction  Moves
//  --------  -------------------------------  ---------  -------------------------
//  s_        s_valid s_ready s_payload         in         one console request
//  m_        m_valid m_ready m_payload         out        one result per request
//  cfg_      cfg_valid cfg_ready cfg_index/data in         colour register write
//
// Sequence: a request that does not scroll is accepted, then the result
// register loads; a cell read uses the registered memory read. A scrolling
// request first sweeps every cell: the copy sweep moves one
// cell per cycle through the single write port of the screen memory.
// Reset: aresetn is synchronous, active low. After reset a clearing pass over
// all ROWS*COLUMNS cells zeroes the screen; s_ready stays low until it is done.
// Configuration writes are taken in every cycle.
// Stalls: a new request is taken only while the result register is empty or
// draining, so a held result stalls the input until it is taken.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  tcw_pkg::tcw_in_t                 s_payload,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output tcw_pkg::tcw_out_t                m_payload,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_LIMIT = ADDR_W'(COPY_COUNT);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DONE   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_fill_reg, pend_fill_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              scrolled_reg, scrolled_next;
    logic [3:0]        fg_reg, bg_reg;
    logic              m_valid_reg, m_valid_next;
    tcw_out_t          m_payload_reg, m_payload_next;

    logic              accept;
    logic              load_result;
    logic [7:0]        attr;

    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [ADDR_W-1:0] cur_pos;
    logic [ADDR_W-1:0] cell_addr;
    tcw_cmd_t          cmd;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    assign attr      = {bg_reg, fg_reg};
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Colour registers: ignore writes to indexes outside the register list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FG_COLOUR) begin
                fg_reg <= cfg_data[3:0];
            end
            if (cfg_index == CFG_BG_COLOUR) begin
                bg_reg <= cfg_data[3:0];
            end
        end
    end

    tcw_cursor #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .COL_W   (COL_W),
        .ROW_W   (ROW_W),
        .ADDR_W  (ADDR_W)
    ) u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .item      (s_payload),
        .cur_col   (cur_col),
        .cur_row   (cur_row),
        .cur_pos   (cur_pos),
        .cell_addr (cell_addr),
        .cmd       (cmd)
    );

    // Memory ports: clear sweep, then pending scroll write, then the request's
    // own cell write. Only one source is live in any state.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr;
        ram_wdata = {attr, cmd.wr_char};
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = '0;
        end else if (pend_valid_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_fill_reg ? {attr, CH_SPACE} : ram_rdata;
        end else if (accept && cmd.wr_en) begin
            ram_we = 1'b1;
        end

        // Scroll reads run one row ahead of the write they feed
        if (state_reg == ST_SCROLL) begin
            ram_raddr = ADDR_W'(sweep_reg + ROW_STRIDE);
        end else begin
            ram_raddr = ADDR_W'(s_payload.cell_index);
        end
    end

    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (16)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        pend_valid_next = 1'b0;
        pend_fill_next  = pend_fill_reg;
        pend_addr_next  = pend_addr_reg;
        rd_ok_next      = rd_ok_reg;
        scrolled_next   = scrolled_reg;
        load_result     = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                // Zero the screen one cell per cycle
                if (sweep_reg == LAST_ADDR) begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = ADDR_W'(sweep_reg + 1'b1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    rd_ok_next    = cmd.rd_en && (int'(s_payload.cell_index) < CELL_COUNT);
                    scrolled_next = cmd.scroll;
                    sweep_next    = '0;
                    state_next    = cmd.scroll ? ST_SCROLL : ST_DONE;
                end
            end
            ST_DONE: begin
                load_result = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SCROLL: begin
                // Queue one write per cycle: copy from the row below, then
                // fill the last row with blanks
                pend_valid_next = 1'b1;
                pend_addr_next  = sweep_reg;
                pend_fill_next  = (sweep_reg >= COPY_LIMIT);
                if (sweep_reg == LAST_ADDR) begin
                    state_next = ST_FINISH;
                end else begin
                    sweep_next = ADDR_W'(sweep_reg + 1'b1);
                end
            end
            ST_FINISH: begin
                // Last pending write drains this cycle
                load_result = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load_result) begin
            m_valid_next              = 1'b1;
            m_payload_next.cursor_col = 7'(cur_col);
            m_payload_next.cursor_row = 5'(cur_row);
            m_payload_next.cursor_pos = 11'(cur_pos);
            m_payload_next.cell_char  = rd_ok_reg ? ram_rdata[7:0] : 8'd0;
            m_payload_next.cell_attr  = rd_ok_reg ? ram_rdata[15:8] : 8'd0;
            m_payload_next.scrolled   = scrolled_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge aclk) begin
        pend_fill_reg <= pend_fill_next;
        pend_addr_reg <= pend_addr_next;
        rd_ok_reg     <= rd_ok_next;
        scrolled_reg  <= scrolled_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

// ===== rtl/core/tcw_screen_ram.sv =====
`timescale 1ns / 1ps
// Screen cell store: simple dual-port memory, one write and one registered read.
// Depends on nothing but the clock.
module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/tcw_cursor.sv =====
`timescale 1ns / 1ps
// Cursor registers and per-request decode: next cursor, cell write, cell read, scroll.
// Depends on tcw_pkg.
module tcw_cursor #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int COL_W   = 7,
    parameter int ROW_W   = 5,
    parameter int ADDR_W  = 11
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  tcw_pkg::tcw_in_t  item,
    output logic [COL_W-1:0]  cur_col,
    output logic [ROW_W-1:0]  cur_row,
    output logic [ADDR_W-1:0] cur_pos,
    output logic [ADDR_W-1:0] cell_addr,
    output tcw_pkg::tcw_cmd_t cmd
);
    import tcw_pkg::*;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic [ROW_W-1:0] set_row;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        cell_col = col_reg;
        cell_row = row_reg;
        cmd      = '0;
        set_row  = (int'(item.new_row) < ROWS) ? ROW_W'(item.new_row) : LAST_ROW;
        case (item.opcode)
            OP_PUT: begin
                case (item.char_code)
                    CH_NEWLINE: begin
                        col_next = '0;
                        if (row_reg == LAST_ROW) begin
                            cmd.scroll = 1'b1;
                        end else begin
                            row_next = ROW_W'(row_reg + 1'b1);
                        end
                    end
                    CH_RETURN: begin
                        col_next = '0;
                    end
                    CH_BACKSPACE: begin
                        if (col_reg != '0) begin
                            cell_col = COL_W'(col_reg - 1'b1);
                        end else if (row_reg != '0) begin
                            cell_row = ROW_W'(row_reg - 1'b1);
                        end
                        col_next    = cell_col;
                        row_next    = cell_row;
                        cmd.wr_en   = 1'b1;
                        cmd.wr_char = CH_SPACE;
                    end
                    default: begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_char = item.char_code;
                        if (col_reg == LAST_COL) begin
                            col_next = '0;
                            if (row_reg == LAST_ROW) begin
                                cmd.scroll = 1'b1;
                            end else begin
                                row_next = ROW_W'(row_reg + 1'b1);
                            end
                        end else begin
                            col_next = COL_W'(col_reg + 1'b1);
                        end
                    end
                endcase
            end
            OP_SET: begin
                row_next = set_row;
                if (int'(item.new_col) >= COLUMNS) begin
                    col_next = '0;
                    if (set_row == LAST_ROW) begin
                        cmd.scroll = 1'b1;
                    end else begin
                        row_next = ROW_W'(set_row + 1'b1);
                    end
                end else begin
                    col_next = COL_W'(item.new_col);
                end
            end
            OP_READ: begin
                cmd.rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign cell_addr = ADDR_W'(int'(cell_row) * COLUMNS + int'(cell_col));
    assign cur_pos   = ADDR_W'(int'(row_reg) * COLUMNS + int'(col_reg));
    assign cur_col   = col_reg;
    assign cur_row   = row_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_console_writer: directed and random console requests,
// each result checked against a screen and cursor predictor kept in the bench.
// Depends on tcw_pkg and the text_console_writer RTL.
module tb;
    import tcw_pkg::*;

    localparam int COLUMNS = DEF_COLUMNS;
    localparam int ROWS    = DEF_ROWS;
    localparam int CELLS   = COLUMNS * ROWS;

    // Opcode the block must treat as a no-op; config index that maps to no register
    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam logic [3:0] CFG_IDX_SPARE = 4'd15;

    localparam int IDLE_PCT           = 37;
    localparam int MAX_RANDOM_SCROLLS = 100;
    // Each scroll costs a full screen sweep; allow every one of them plus all
    // requests stalling on both sides, then take that several times over.
    localparam int CYCLE_LIMIT        = 2_000_000;
    localparam int SETTLE_CYCLES      = 32;
    localparam int REPORT_MAX         = 10;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    tcw_in_t           s_payload = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    tcw_out_t          m_payload;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]        cfg_data  = '0;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Console predictor: screen copy, cursor and colour registers
    // ------------------------------------------------------------------
    logic [15:0]  screen_model [CELLS] = '{default: '0};
    int unsigned  crs_col = 0;
    int unsigned  crs_row = 0;
    logic [3:0]   fg_q    = FG_RESET;
    logic [3:0]   bg_q    = BG_RESET;

    tcw_out_t     console_reports_due[$];
    int unsigned  fail_count   = 0;
    int unsigned  scroll_count = 0;
    int unsigned  cycle_count  = 0;

    // Shared control between the request sender and the result monitor
    bit           steady       = 1'b0;   // suppress random idling on both sides
    int unsigned  rx_hold_req  = 0;      // ask the monitor for a long hold-off
    int unsigned  rx_hold_left = 0;

    // Attribute byte is background in the high nibble, foreground in the low
    function automatic logic [15:0] attr_cell(input logic [7:0] ch);
        return {bg_q, fg_q, ch};
    endfunction

    function automatic void store_cell(input int unsigned col, input int unsigned row,
                                       input logic [7:0] ch);
        if (col < COLUMNS && row * COLUMNS + col < CELLS)
            screen_model[row * COLUMNS + col] = attr_cell(ch);
    endfunction

    // Move every row up one and blank the bottom row in the current colours
    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = attr_cell(CH_SPACE);
    endfunction

    // Column 0 of the next row; scroll when passing the bottom row
    function automatic bit line_feed();
        crs_col = 0;
        crs_row++;
        if (crs_row >= ROWS) begin
            scroll_screen();
            crs_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the predictor by one request and build the report it yields
    function automatic void apply_console_request(input tcw_in_t rq, output tcw_out_t rs);
        bit          scr   = 1'b0;
        logic [7:0]  rd_ch = '0;
        logic [7:0]  rd_at = '0;
        int unsigned pos;
        case (rq.opcode)
            OP_PUT: begin
                if (rq.char_code == CH_NEWLINE) begin
                    scr = line_feed();
                end else if (rq.char_code == CH_RETURN) begin
                    crs_col = 0;
                end else if (rq.char_code == CH_BACKSPACE) begin
                    // step back; at column 0 climb one row, never above row 0
                    if (crs_col > 0)
                        crs_col--;
                    else if (crs_row > 0)
                        crs_row--;
                    store_cell(crs_col, crs_row, CH_SPACE);
                end else begin
                    store_cell(crs_col, crs_row, rq.char_code);
                    crs_col++;
                    if (crs_col >= COLUMNS)
                        scr = line_feed();
                end
            end
            OP_SET: begin
                // clamp the row, wrap an overflowing column onto the next row
                crs_row = (rq.new_row < ROWS) ? 32'(rq.new_row) : ROWS - 1;
                crs_col = 32'(rq.new_col);
                if (crs_col >= COLUMNS)
                    scr = line_feed();
            end
            OP_READ: begin
                if (rq.cell_index < CELLS)
                    {rd_at, rd_ch} = screen_model[rq.cell_index];
            end
            default: ;
        endcase
        pos           = crs_row * COLUMNS + crs_col;
        rs.cursor_col = crs_col[6:0];
        rs.cursor_row = crs_row[4:0];
        rs.cursor_pos = pos[10:0];
        rs.cell_char  = rd_ch;
        rs.cell_attr  = rd_at;
        rs.scrolled   = scr;
    endfunction

    function automatic bit would_scroll(input tcw_in_t rq);
        case (rq.opcode)
            OP_PUT: begin
                if (rq.char_code == CH_NEWLINE)
                    return crs_row == ROWS - 1;
                if (rq.char_code inside {CH_RETURN, CH_BACKSPACE})
                    return 1'b0;
                return crs_row == ROWS - 1 && crs_col == COLUMNS - 1;
            end
            OP_SET:  return rq.new_col >= COLUMNS && rq.new_row >= ROWS - 1;
            default: return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: check every accepted result, drive m_ready
    // ------------------------------------------------------------------
    function automatic void note_failure(input string what, input int unsigned want_v,
                                         input int unsigned got_v);
        if (fail_count < REPORT_MAX)
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, want_v, got_v);
        fail_count++;
    endfunction

    task automatic check_result(input tcw_out_t got);
        tcw_out_t want;
        if (console_reports_due.size() == 0) begin
            note_failure("outstanding request count", 0, 1);
            return;
        end
        want = console_reports_due.pop_front();
        if (got.cursor_col !== want.cursor_col)
            note_failure("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
        if (got.cursor_row !== want.cursor_row)
            note_failure("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
        if (got.cursor_pos !== want.cursor_pos)
            note_failure("cursor_pos", 32'(want.cursor_pos), 32'(got.cursor_pos));
        if (got.cell_char !== want.cell_char)
            note_failure("cell_char", 32'(want.cell_char), 32'(got.cell_char));
        if (got.cell_attr !== want.cell_attr)
            note_failure("cell_attr", 32'(want.cell_attr), 32'(got.cell_attr));
        if (got.scrolled !== want.scrolled)
            note_failure("scrolled", 32'(want.scrolled), 32'(got.scrolled));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result(m_payload);
        // pick up a hold-off request and count it down here, cycle by cycle
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("text_console_writer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request, hold it until taken, then log the report it owes.
    // Within this task, valid is dropped only during a random gap before the request.
    task automatic send_request(input tcw_in_t rq);
        tcw_out_t want;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= rq;
        do @(posedge aclk); while (!s_ready);
        apply_console_request(rq, want);
        console_reports_due.push_back(want);
    endtask

    // Drop valid and hold until every owed report has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (console_reports_due.size() != 0);
    endtask

    // Random filler in every field, so unused fields toggle too
    function automatic tcw_in_t random_fields(input logic [1:0] op);
        tcw_in_t rq;
        rq.opcode     = op;
        rq.char_code  = 8'($urandom_range(255));
        rq.new_col    = 8'($urandom_range(255));
        rq.new_row    = 8'($urandom_range(255));
        rq.cell_index = 11'($urandom_range(2047));
        return rq;
    endfunction

    task automatic put_char(input logic [7:0] ch);
        tcw_in_t rq;
        rq = random_fields(OP_PUT);
        rq.char_code = ch;
        send_request(rq);
    endtask

    task automatic move_cursor(input logic [7:0] col, input logic [7:0] row);
        tcw_in_t rq;
        rq = random_fields(OP_SET);
        rq.new_col = col;
        rq.new_row = row;
        send_request(rq);
    endtask

    task automatic read_cell(input logic [10:0] idx);
        tcw_in_t rq;
        rq = random_fields(OP_READ);
        rq.cell_index = idx;
        send_request(rq);
    endtask

    // Keep cfg_valid high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FG_COLOUR: fg_q = val[3:0];
            CFG_BG_COLOUR: bg_q = val[3:0];
            default: ;
        endcase
    endtask

    // Change colours only with the block idle; upper data bits are don't-care
    task automatic set_colours(input logic [3:0] fg, input logic [3:0] bg);
        wait_drained();
        write_reg(CFG_FG_COLOUR, {4'($urandom_range(15)), fg});
        write_reg(CFG_BG_COLOUR, {4'($urandom_range(15)), bg});
        write_reg(CFG_IDX_SPARE, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    // Mostly text with control characters, cursor moves and read-backs
    function automatic tcw_in_t random_request();
        tcw_in_t     rq;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            rq = random_fields(OP_PUT);
        end else if (pick < 62) begin
            rq = random_fields(OP_PUT);
            if (pick < 52)
                rq.char_code = CH_NEWLINE;
            else if (pick < 56)
                rq.char_code = CH_RETURN;
            else
                rq.char_code = CH_BACKSPACE;
        end else if (pick < 75) begin
            rq = random_fields(OP_SET);
            if ($urandom_range(3) != 0) begin
                rq.new_col = 8'($urandom_range(COLUMNS - 1));
                rq.new_row = 8'($urandom_range(ROWS - 1));
            end
        end else if (pick < 96) begin
            rq = random_fields(OP_READ);
            // half the reads land on the cursor row, where text was just written
            if ($urandom_range(1) == 0)
                rq.cell_index = 11'(crs_row * COLUMNS + $urandom_range(COLUMNS - 1));
        end else begin
            rq = random_fields(OP_NONE);
        end
        return rq;
    endfunction

    // Let about one scroll in three through, capped; turn the rest into a
    // cursor move that cannot scroll, so sweeps stay affordable
    task automatic send_random(input int unsigned count);
        tcw_in_t rq;
        repeat (count) begin
            rq = random_request();
            if (would_scroll(rq)) begin
                if (scroll_count < MAX_RANDOM_SCROLLS && $urandom_range(2) == 0) begin
                    scroll_count++;
                end else begin
                    rq.opcode  = OP_SET;
                    rq.new_col = 8'($urandom_range(COLUMNS - 1));
                    rq.new_row = 8'($urandom_range(ROWS - 2));
                end
            end
            send_request(rq);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Screen must come out of the clearing pass all zero
    task automatic test_after_reset();
        read_cell(11'd0);
        read_cell(11'(CELLS - 1));
    endtask

    // Printable, return, newline, backspace from column 0 of a lower row and at the home cell
    task automatic test_control_chars();
        put_char(8'h41);
        read_cell(11'd0);
        put_char(CH_RETURN);
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        put_char(CH_BACKSPACE);
    endtask

    // Wrap at the line end, row clamp, column overflow onto the next row
    task automatic test_cursor_limits();
        move_cursor(8'(COLUMNS - 1), 8'd0);
        put_char(8'hFF);
        move_cursor(8'd0, 8'd255);
        move_cursor(8'd200, 8'd10);
    endtask

    // Scroll from a printable at the last cell, a newline and a set cursor
    task automatic test_scroll();
        move_cursor(8'(COLUMNS - 1), 8'(ROWS - 1));
        put_char(8'h00);
        put_char(CH_NEWLINE);
        move_cursor(8'd255, 8'd255);
        read_cell(11'(CELLS - 1));
    endtask

    // Reads past the screen return zero; the spare opcode is a no-op
    task automatic test_read_range();
        read_cell(11'(CELLS));
        read_cell(11'h7FF);
        send_request(random_fields(OP_NONE));
    endtask

    // Extreme colour settings show up in written cells
    task automatic test_colours();
        set_colours(4'h0, 4'h0);
        move_cursor(8'd3, 8'd3);
        put_char(8'h5A);
        read_cell(11'(3 * COLUMNS + 3));
        set_colours(4'hF, 4'hF);
        put_char(8'h7E);
        read_cell(11'(3 * COLUMNS + 4));
    endtask

    // Hold results off while requests keep coming, then pause until drained
    task automatic test_backpressure();
        wait_drained();
        rx_hold_req = 400;
        steady      = 1'b1;
        send_random(24);
        steady      = 1'b0;
        wait_drained();
    endtask

    // Random text in four colour phases; one phase opens with no idling at all
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       set_colours(4'hF, 4'h0);
                2:       set_colours(4'h0, 4'hF);
                default: set_colours(4'($urandom_range(15)), 4'($urandom_range(15)));
            endcase
            if (phase == 1) begin
                steady = 1'b1;
                send_random(200);
                steady = 1'b0;
                send_random(140);
            end else begin
                send_random(340);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_control_chars();
        test_cursor_limits();
        test_scroll();
        test_read_range();
        test_colours();
        test_backpressure();
        test_random_traffic();

        // Wait for the last report, then watch a while for stray results
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("text_console_writer regression: pass");
        else
            $display("text_console_writer regression: fail");
        $finish;
    end

endmodule
